// ===== hdl/rv32_control_decoder_unit_defines.svh =====
// assertion macros for the control decoder unit
`ifndef RV32_CONTROL_DECODER_UNIT_DEFINES_SVH
`define RV32_CONTROL_DECODER_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define RCD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define RCD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/rv32cd_pkg.sv =====
// shared types and constants of the rv32 control decoder
`default_nettype none
package rv32cd_pkg;

    localparam logic [4:0] OP_LUI    = 5'b01101;
    localparam logic [4:0] OP_AUIPC  = 5'b00101;
    localparam logic [4:0] OP_JAL    = 5'b11011;
    localparam logic [4:0] OP_JALR   = 5'b11001;
    localparam logic [4:0] OP_BRANCH = 5'b11000;
    localparam logic [4:0] OP_LOAD   = 5'b00000;
    localparam logic [4:0] OP_STORE  = 5'b01000;
    localparam logic [4:0] OP_IMM    = 5'b00100;
    localparam logic [4:0] OP_REG    = 5'b01100;
    localparam logic [4:0] OP_SYS    = 5'b11100;

    localparam logic [11:0] CSR_MTVEC   = 12'h305;
    localparam logic [11:0] CSR_MEPC    = 12'h341;
    localparam logic [11:0] CSR_MCAUSE  = 12'h342;
    localparam logic [11:0] CSR_MSTATUS = 12'h300;

    typedef struct packed {
        logic [4:0]  opcode_bits;
        logic [2:0]  funct3;
        logic        alt_bit;
        logic [4:0]  dest_reg;
        logic [2:0]  compare_flags_n;
        logic [1:0]  system_code;
        logic        status_flag;
        logic        timer_irq_n;
        logic        ext_irq_n;
        logic [11:0] csr_address;
    } t_dec_in;

    typedef struct packed {
        logic [5:0] pc_select_n;
        logic [7:0] operand_select_n;
        logic [7:0] alu_control;
        logic [7:0] mem_op_n;
        logic [7:0] csr_control_n;
        logic [6:0] irq_control;
        logic [7:0] csr_reg_enable_n;
        logic [5:0] gpr_control_n;
    } t_dec_out;

endpackage
`default_nettype wire

// ===== hdl/rv32cd_decode.sv =====
// combinational decode of one instruction into the control words
`default_nettype none
module rv32cd_decode (
    input  rv32cd_pkg::t_dec_in  i_dec,
    output rv32cd_pkg::t_dec_out o_dec
);
    import rv32cd_pkg::*;

    logic [4:0] op;
    logic [2:0] f3;
    logic       z, lt, ltu, taken;
    logic       is_jump, is_arith, is_upper, sys0, st;
    logic [3:0] pc_off;
    logic [1:0] pc_base;
    logic [2:0] src_a;
    logic [4:0] src_b;
    logic [2:0] alu_fn, shift_op;
    logic [1:0] set_op;
    logic [4:0] load_op;
    logic [2:0] store_op;
    logic [3:0] csr_op;
    logic [1:0] csr_src, exc;
    logic       ti_en, ei_en, mret, hnd, flag, cen;
    logic       oe_tv, oe_ep, oe_ca, oe_st;
    logic [4:0] gpr_sel;
    logic       gpr_we;

    always_comb begin
        op       = i_dec.opcode_bits;
        f3       = i_dec.funct3;
        st       = i_dec.status_flag;
        z        = i_dec.compare_flags_n[2];
        lt       = i_dec.compare_flags_n[1];
        ltu      = i_dec.compare_flags_n[0];
        is_jump  = (op == OP_JAL) || (op == OP_JALR);
        is_arith = (op == OP_IMM) || (op == OP_REG);
        is_upper = (op == OP_LUI) || (op == OP_AUIPC);
        sys0     = (op == OP_SYS) && (f3 == 3'd0);

        // next pc
        unique case (f3)
            3'd0:    taken = !z;
            3'd1:    taken = z;
            3'd4:    taken = !lt;
            3'd5:    taken = lt;
            3'd6:    taken = !ltu;
            3'd7:    taken = ltu;
            default: taken = 1'b0;
        endcase
        pc_base = (op == OP_JALR) ? 2'b10 : 2'b01;
        priority if (op == OP_JAL)    pc_off = 4'hE;
        else if (op == OP_JALR)       pc_off = 4'hD;
        else if (op == OP_BRANCH)     pc_off = taken ? 4'hB : 4'hF;
        else                          pc_off = 4'h7;

        // operand select
        priority if ((op == OP_AUIPC) || is_jump) src_a = 3'd6;
        else if (op == OP_LUI)                    src_a = 3'd5;
        else if ((op == OP_LOAD) || (op == OP_STORE) || is_arith || (op == OP_BRANCH))
            src_a = 3'd3;
        else
            src_a = 3'd7;
        priority if (is_jump)                              src_b = 5'h1E;
        else if (is_upper)                                 src_b = 5'h1D;
        else if ((op == OP_LOAD) || (op == OP_IMM))        src_b = 5'h1B;
        else if (op == OP_STORE)                           src_b = 5'h17;
        else if ((op == OP_REG) || (op == OP_BRANCH))      src_b = 5'h0F;
        else                                               src_b = 5'h1F;

        // alu, shift and set
        alu_fn = 3'd0;
        if (is_upper || is_jump || (op == OP_LOAD) || (op == OP_STORE)) begin
            alu_fn = 3'd3;
        end else if (op == OP_BRANCH) begin
            alu_fn = 3'd2;
        end else if (is_arith) begin
            unique case (f3)
                3'd0:    alu_fn = ((op == OP_REG) && i_dec.alt_bit) ? 3'd2 : 3'd3;
                3'd4:    alu_fn = 3'd4;
                3'd6:    alu_fn = 3'd5;
                3'd7:    alu_fn = 3'd6;
                default: alu_fn = 3'd0;
            endcase
        end
        shift_op = 3'd7;
        set_op   = 2'd3;
        if (is_arith) begin
            if (f3 == 3'd1)      shift_op = 3'd3;
            else if (f3 == 3'd5) shift_op = i_dec.alt_bit ? 3'd6 : 3'd5;
            if (f3 == 3'd2)      set_op = 2'd1;
            else if (f3 == 3'd3) set_op = 2'd2;
        end

        // load and store
        load_op  = 5'h1F;
        store_op = 3'd7;
        if (op == OP_LOAD) begin
            unique case (f3)
                3'd5:    load_op = 5'h0F;
                3'd4:    load_op = 5'h17;
                3'd2:    load_op = 5'h1B;
                3'd1:    load_op = 5'h1D;
                3'd0:    load_op = 5'h1E;
                default: load_op = 5'h1F;
            endcase
        end
        if (op == OP_STORE) begin
            unique case (f3)
                3'd2:    store_op = 3'd3;
                3'd1:    store_op = 3'd5;
                3'd0:    store_op = 3'd6;
                default: store_op = 3'd7;
            endcase
        end

        // csr operation and exceptions
        csr_op  = 4'hF;
        csr_src = 2'd3;
        exc     = 2'd3;
        if (op == OP_SYS) begin
            unique case (f3[1:0])
                2'd1:    csr_op = 4'h3;
                2'd2:    csr_op = 4'h5;
                2'd3:    csr_op = 4'h6;
                default: csr_op = 4'hF;
            endcase
            if (f3 >= 3'd5)                       csr_src = 2'd1;
            else if ((f3 >= 3'd1) && (f3 <= 3'd3)) csr_src = 2'd2;
            if (st && (i_dec.system_code == 2'd0))      exc = 2'd2;
            else if (st && (i_dec.system_code == 2'd1)) exc = 2'd1;
        end
        cen = csr_op[3];

        // interrupt control
        ti_en = !(!i_dec.timer_irq_n && st);
        ei_en = !(!i_dec.ext_irq_n && st);
        mret  = !(sys0 && !st);
        hnd   = !(!ti_en || !ei_en || (sys0 && st));
        flag  = hnd && mret;

        // csr register enables
        oe_tv = !(!cen && (i_dec.csr_address == CSR_MTVEC));
        oe_ep = !(!cen && (i_dec.csr_address == CSR_MEPC));
        oe_ca = !(!cen && (i_dec.csr_address == CSR_MCAUSE));
        oe_st = !(!cen && (i_dec.csr_address == CSR_MSTATUS));

        // gpr source and write
        priority if (is_upper || is_jump || (op == OP_BRANCH))
            gpr_sel = 5'h1E;
        else if (is_arith && ((f3 == 3'd2) || (f3 == 3'd3)))
            gpr_sel = 5'h1D;
        else if ((op == OP_LOAD) && (f3 != 3'd3) && (f3 != 3'd6) && (f3 != 3'd7))
            gpr_sel = 5'h1B;
        else if (is_arith && ((f3 == 3'd1) || (f3 == 3'd5)))
            gpr_sel = 5'h17;
        else
            gpr_sel = 5'h0F;
        gpr_we = !((is_upper || is_jump || (op == OP_LOAD) || is_arith ||
                    ((op == OP_SYS) && (f3 != 3'd0) && (f3 != 3'd4))) &&
                   (i_dec.dest_reg != 5'd0));

        o_dec.pc_select_n      = {pc_off, pc_base};
        o_dec.operand_select_n = {src_b, src_a};
        o_dec.alu_control      = {set_op, shift_op, alu_fn};
        o_dec.mem_op_n         = {store_op, load_op};
        o_dec.csr_control_n    = {exc, csr_src, csr_op};
        o_dec.irq_control      = {flag, !hnd, hnd, !mret, mret, ei_en, ti_en};
        o_dec.csr_reg_enable_n = {oe_st, oe_ca, oe_ep, oe_tv,
                                  oe_st && flag, hnd, oe_ep && hnd, oe_tv};
        o_dec.gpr_control_n    = {gpr_we, gpr_sel};
    end

endmodule
`default_nettype wire

// ===== hdl/rv32_control_decoder_unit.sv =====
// top level: input register, control decode, result register
// an input beat passes the input register, then the result register
// throughput: one beat per cycle unless the output stalls, set by the two-stage register pipeline
// a stalled output holds one beat and the input stage keeps one more
// reset (synchronous, active low) empties both stages
`default_nettype none
`include "rv32_control_decoder_unit_defines.svh"
module rv32_control_decoder_unit (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    output logic                  o_in_ready,
    input  rv32cd_pkg::t_dec_in   i_in_data,
    output logic                  o_out_valid,
    input  wire                   i_out_ready,
    output rv32cd_pkg::t_dec_out  o_out_data
);
    import rv32cd_pkg::*;

    logic     r_in_valid, n_in_valid;
    t_dec_in  r_in_data;
    logic     r_out_valid, n_out_valid;
    t_dec_out r_out_data;
    t_dec_out dec_word;
    logic     out_load;

    rv32cd_decode u_decode (
        .i_dec (r_in_data),
        .o_dec (dec_word)
    );

    assign out_load    = !r_out_valid || i_out_ready;
    assign o_in_ready  = !r_in_valid || out_load;
    assign n_in_valid  = (i_in_valid && o_in_ready) || (r_in_valid && !out_load);
    assign n_out_valid = out_load ? r_in_valid : r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_data <= i_in_data;
        end
        if (out_load && r_in_valid) begin
            r_out_data <= dec_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    `RCD_ASSERT_NEXT(a_stage_moves, r_in_valid && out_load, r_out_valid,
        "decoded beat not moved to output")
    `RCD_ASSERT_NOW(a_ready_only_full, !o_in_ready,
        r_in_valid && r_out_valid && !i_out_ready, "input stalled without full pipe")
    `RCD_ASSERT_NOW(a_csr_oe_needs_en, o_out_valid && !o_out_data.csr_reg_enable_n[4],
        !o_out_data.csr_control_n[3], "csr output enable without csr enable")

endmodule
`default_nettype wire

// ===== test/tb_rv32_control_decoder_unit.sv =====
// testbench for the rv32 control decoder: random and directed beats against a decode predictor
`default_nettype none
module tb_rv32_control_decoder_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import rv32cd_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_BEATS = 850;
    localparam int DRAIN_CYCLES = 10;

    localparam logic [4:0] OP_UNKNOWN = 5'b11111;

    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SR   = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;

    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;
    localparam logic [2:0] F3_BRSV = 3'd2;
    localparam logic [2:0] F3_BLT  = 3'd4;
    localparam logic [2:0] F3_BGE  = 3'd5;
    localparam logic [2:0] F3_BLTU = 3'd6;
    localparam logic [2:0] F3_BGEU = 3'd7;

    localparam logic [2:0] F3_LB   = 3'd0;
    localparam logic [2:0] F3_LH   = 3'd1;
    localparam logic [2:0] F3_LW   = 3'd2;
    localparam logic [2:0] F3_LRSV = 3'd3;
    localparam logic [2:0] F3_LBU  = 3'd4;
    localparam logic [2:0] F3_LHU  = 3'd5;

    localparam logic [2:0] F3_SB   = 3'd0;
    localparam logic [2:0] F3_SH   = 3'd1;
    localparam logic [2:0] F3_SW   = 3'd2;

    localparam logic [2:0] F3_PRIV   = 3'd0;
    localparam logic [2:0] F3_CSRRW  = 3'd1;
    localparam logic [2:0] F3_CSRRS  = 3'd2;
    localparam logic [2:0] F3_CSRRC  = 3'd3;
    localparam logic [2:0] F3_SYSRSV = 3'd4;
    localparam logic [2:0] F3_CSRRWI = 3'd5;
    localparam logic [2:0] F3_CSRRSI = 3'd6;

    localparam logic [1:0] SYS_ECALL  = 2'd0;
    localparam logic [1:0] SYS_EBREAK = 2'd1;

    localparam logic [2:0] ALU_NONE = 3'd0;
    localparam logic [2:0] ALU_SUB  = 3'd2;
    localparam logic [2:0] ALU_ADD  = 3'd3;
    localparam logic [2:0] ALU_XOR  = 3'd4;
    localparam logic [2:0] ALU_OR   = 3'd5;
    localparam logic [2:0] ALU_AND  = 3'd6;

    class ctrl_board;
        t_dec_out due_q[$];
        int mismatches;

        function new();
            mismatches = 0;
        endfunction

        function t_dec_out decode_controls(t_dec_in d);
            t_dec_out r;
            logic [4:0] op;
            logic [2:0] f3;
            logic z, lt, ltu, taken, arith;
            logic [3:0] off;
            logic [1:0] base;
            logic [2:0] src_a;
            logic [4:0] src_b;
            logic [2:0] fn, sh;
            logic [1:0] setop;
            logic [4:0] ld;
            logic [2:0] sw;
            logic [3:0] cop;
            logic [1:0] csrc, exc;
            logic ti_en, ei_en, sys0, mret, hnd, flag, on;
            logic oe_tv, oe_ep, oe_ca, oe_st;
            logic [4:0] sel;
            logic we;

            op = d.opcode_bits;
            f3 = d.funct3;
            {z, lt, ltu} = d.compare_flags_n;
            arith = (op == OP_IMM) || (op == OP_REG);

            // next pc
            taken = (f3 == F3_BEQ && !z) || (f3 == F3_BNE && z) ||
                    (f3 == F3_BLT && !lt) || (f3 == F3_BGE && lt) ||
                    (f3 == F3_BLTU && !ltu) || (f3 == F3_BGEU && ltu);
            if (op == OP_JAL) off = 4'b1110;
            else if (op == OP_JALR) off = 4'b1101;
            else if (op == OP_BRANCH) off = taken ? 4'b1011 : 4'b1111;
            else off = 4'b0111;
            base = (op == OP_JALR) ? 2'b10 : 2'b01;
            r.pc_select_n = {off, base};

            // operands
            src_a = 3'b111;
            if (op inside {OP_AUIPC, OP_JAL, OP_JALR}) src_a = 3'b110;
            else if (op == OP_LUI) src_a = 3'b101;
            else if (op inside {OP_LOAD, OP_STORE, OP_IMM, OP_REG, OP_BRANCH}) src_a = 3'b011;
            src_b = 5'b11111;
            if (op inside {OP_JAL, OP_JALR}) src_b = 5'b11110;
            else if (op inside {OP_LUI, OP_AUIPC}) src_b = 5'b11101;
            else if (op inside {OP_LOAD, OP_IMM}) src_b = 5'b11011;
            else if (op == OP_STORE) src_b = 5'b10111;
            else if (op inside {OP_REG, OP_BRANCH}) src_b = 5'b01111;
            r.operand_select_n = {src_b, src_a};

            // alu, shift, set
            fn = ALU_NONE;
            sh = 3'b111;
            setop = 2'b11;
            if (op inside {OP_LUI, OP_AUIPC, OP_JAL, OP_JALR, OP_LOAD, OP_STORE}) begin
                fn = ALU_ADD;
            end else if (op == OP_BRANCH) begin
                fn = ALU_SUB;
            end else if (arith) begin
                case (f3)
                    F3_ADD: fn = (op == OP_REG && d.alt_bit) ? ALU_SUB : ALU_ADD;
                    F3_XOR: fn = ALU_XOR;
                    F3_OR:  fn = ALU_OR;
                    F3_AND: fn = ALU_AND;
                    default: fn = ALU_NONE;
                endcase
            end
            if (arith) begin
                if (f3 == F3_SLL) sh = 3'b011;
                else if (f3 == F3_SR) sh = d.alt_bit ? 3'b110 : 3'b101;
                if (f3 == F3_SLT) setop = 2'b01;
                else if (f3 == F3_SLTU) setop = 2'b10;
            end
            r.alu_control = {setop, sh, fn};

            // load and store
            ld = 5'b11111;
            sw = 3'b111;
            if (op == OP_LOAD) begin
                case (f3)
                    F3_LHU: ld = 5'b01111;
                    F3_LBU: ld = 5'b10111;
                    F3_LW:  ld = 5'b11011;
                    F3_LH:  ld = 5'b11101;
                    F3_LB:  ld = 5'b11110;
                    default: ld = 5'b11111;
                endcase
            end
            if (op == OP_STORE) begin
                case (f3)
                    F3_SW: sw = 3'b011;
                    F3_SH: sw = 3'b101;
                    F3_SB: sw = 3'b110;
                    default: sw = 3'b111;
                endcase
            end
            r.mem_op_n = {sw, ld};

            // csr operation and exceptions
            cop = 4'b1111;
            csrc = 2'b11;
            exc = 2'b11;
            if (op == OP_SYS) begin
                case (f3[1:0])
                    2'b01: cop = 4'b0011;
                    2'b10: cop = 4'b0101;
                    2'b11: cop = 4'b0110;
                    default: cop = 4'b1111;
                endcase
                if (f3[1:0] != 2'b00) csrc = f3[2] ? 2'b01 : 2'b10;
                if (d.status_flag && d.system_code == SYS_ECALL) exc = 2'b10;
                else if (d.status_flag && d.system_code == SYS_EBREAK) exc = 2'b01;
            end
            r.csr_control_n = {exc, csrc, cop};

            // interrupts and mret
            ti_en = !(!d.timer_irq_n && d.status_flag);
            ei_en = !(!d.ext_irq_n && d.status_flag);
            sys0 = (op == OP_SYS) && (f3 == F3_PRIV);
            mret = !(sys0 && !d.status_flag);
            hnd = !(!ti_en || !ei_en || (sys0 && d.status_flag));
            flag = hnd && mret;
            r.irq_control = {flag, !hnd, hnd, !mret, mret, ei_en, ti_en};

            // csr register enables
            on = !cop[3];
            oe_tv = !(on && d.csr_address == CSR_MTVEC);
            oe_ep = !(on && d.csr_address == CSR_MEPC);
            oe_ca = !(on && d.csr_address == CSR_MCAUSE);
            oe_st = !(on && d.csr_address == CSR_MSTATUS);
            r.csr_reg_enable_n = {oe_st, oe_ca, oe_ep, oe_tv,
                                  oe_st && flag, hnd, oe_ep && hnd, oe_tv};

            // register file write
            if (op inside {OP_LUI, OP_AUIPC, OP_JAL, OP_JALR, OP_BRANCH}) sel = 5'b11110;
            else if (arith && (f3 == F3_SLT || f3 == F3_SLTU)) sel = 5'b11101;
            else if (op == OP_LOAD && (f3 inside {F3_LB, F3_LH, F3_LW, F3_LBU, F3_LHU}))
                sel = 5'b11011;
            else if (arith && (f3 == F3_SLL || f3 == F3_SR)) sel = 5'b10111;
            else sel = 5'b01111;
            we = 1'b1;
            if ((op inside {OP_LUI, OP_AUIPC, OP_JAL, OP_JALR, OP_LOAD} || arith ||
                 (op == OP_SYS && f3 != F3_PRIV && f3 != F3_SYSRSV)) && d.dest_reg != 5'd0)
                we = 1'b0;
            r.gpr_control_n = {we, sel};
            return r;
        endfunction

        function void note_instr(t_dec_in d);
            due_q.push_back(decode_controls(d));
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $error("%s: expected %h, got %h", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_controls(t_dec_out got);
            t_dec_out want;
            if (due_q.size() == 0) begin
                $error("output beat with nothing pending: %h", got);
                mismatches++;
                return;
            end
            want = due_q.pop_front();
            compare_field("pc_select_n", 8'(want.pc_select_n), 8'(got.pc_select_n));
            compare_field("operand_select_n", want.operand_select_n, got.operand_select_n);
            compare_field("alu_control", want.alu_control, got.alu_control);
            compare_field("mem_op_n", want.mem_op_n, got.mem_op_n);
            compare_field("csr_control_n", want.csr_control_n, got.csr_control_n);
            compare_field("irq_control", 8'(want.irq_control), 8'(got.irq_control));
            compare_field("csr_reg_enable_n", want.csr_reg_enable_n, got.csr_reg_enable_n);
            compare_field("gpr_control_n", 8'(want.gpr_control_n), 8'(got.gpr_control_n));
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    t_dec_in in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    t_dec_out out_data;

    int src_idle_pct = 0;
    int sink_idle_pct = 0;
    int cycle_count = 0;

    logic [4:0] known_ops [10] = '{OP_LUI, OP_AUIPC, OP_JAL, OP_JALR, OP_BRANCH,
                                   OP_LOAD, OP_STORE, OP_IMM, OP_REG, OP_SYS};
    logic [11:0] csr_set [4] = '{CSR_MTVEC, CSR_MEPC, CSR_MCAUSE, CSR_MSTATUS};

    ctrl_board board = new();

    rv32_control_decoder_unit uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    always #10 clk = ~clk;

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) board.check_controls(out_data);
        out_ready <= rst_n && ($urandom_range(99) >= sink_idle_pct);
    end

    function automatic t_dec_in random_instr();
        logic [63:0] raw;
        t_dec_in d;
        raw = {$urandom, $urandom};
        d = raw[$bits(t_dec_in)-1:0];
        if ($urandom_range(99) < 80) d.opcode_bits = known_ops[$urandom_range(9)];
        if ($urandom_range(99) < 50) d.csr_address = csr_set[$urandom_range(3)];
        if ($urandom_range(7) == 0) d.dest_reg = 5'd0;
        return d;
    endfunction

    task automatic send_beat(input t_dec_in d);
        while ($urandom_range(99) < src_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= d;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        board.note_instr(d);
    endtask

    task automatic run_phase(input int src_pct, input int sink_pct, input int beats);
        src_idle_pct = src_pct;
        sink_idle_pct = sink_pct;
        repeat (beats) send_beat(random_instr());
    endtask

    // field order: opcode, funct3, alt, rd, flags_n, code, status, timer_n, ext_n, csr
    task automatic send_directed();
        send_beat('0);
        send_beat('1);
        foreach (known_ops[i]) begin
            if (i < 4) send_beat(t_dec_in'{known_ops[i], F3_ADD, 1'b0, 5'd5, 3'b111,
                                           SYS_EBREAK, 1'b0, 1'b1, 1'b1, 12'hfff});
        end
        send_beat(t_dec_in'{OP_UNKNOWN, F3_SLT, 1'b1, 5'd6, 3'b000, SYS_ECALL, 1'b1, 1'b0,
                            1'b0, CSR_MTVEC});
        send_beat(t_dec_in'{OP_BRANCH, F3_BEQ, 1'b0, 5'd0, 3'b011, SYS_ECALL, 1'b0, 1'b1,
                            1'b1, 12'h000});
        send_beat(t_dec_in'{OP_BRANCH, F3_BNE, 1'b0, 5'd0, 3'b011, SYS_ECALL, 1'b0, 1'b1,
                            1'b1, 12'h000});
        send_beat(t_dec_in'{OP_BRANCH, F3_BLTU, 1'b1, 5'd3, 3'b110, SYS_ECALL, 1'b0, 1'b1,
                            1'b1, 12'h000});
        send_beat(t_dec_in'{OP_BRANCH, F3_BRSV, 1'b0, 5'd3, 3'b000, SYS_ECALL, 1'b0, 1'b1,
                            1'b1, 12'h000});
        send_beat(t_dec_in'{OP_LOAD, F3_LHU, 1'b0, 5'd31, 3'b111, SYS_ECALL, 1'b0, 1'b1,
                            1'b1, 12'h000});
        send_beat(t_dec_in'{OP_LOAD, F3_LRSV, 1'b0, 5'd31, 3'b111, SYS_ECALL, 1'b0, 1'b1,
                            1'b1, 12'h000});
        send_beat(t_dec_in'{OP_STORE, F3_SW, 1'b0, 5'd9, 3'b111, SYS_ECALL, 1'b0, 1'b1,
                            1'b1, 12'h000});
        send_beat(t_dec_in'{OP_REG, F3_ADD, 1'b1, 5'd1, 3'b111, SYS_ECALL, 1'b0, 1'b1,
                            1'b1, 12'h000});
        send_beat(t_dec_in'{OP_REG, F3_SR, 1'b1, 5'd2, 3'b111, SYS_ECALL, 1'b0, 1'b1,
                            1'b1, 12'h000});
        send_beat(t_dec_in'{OP_IMM, F3_SLTU, 1'b0, 5'd4, 3'b111, SYS_ECALL, 1'b0, 1'b1,
                            1'b1, 12'h000});
        send_beat(t_dec_in'{OP_IMM, F3_AND, 1'b0, 5'd0, 3'b111, SYS_ECALL, 1'b0, 1'b1,
                            1'b1, 12'h000});
        send_beat(t_dec_in'{OP_SYS, F3_PRIV, 1'b0, 5'd0, 3'b111, SYS_ECALL, 1'b1, 1'b1,
                            1'b1, 12'h000});
        send_beat(t_dec_in'{OP_SYS, F3_PRIV, 1'b0, 5'd0, 3'b111, SYS_EBREAK, 1'b1, 1'b1,
                            1'b1, 12'h000});
        send_beat(t_dec_in'{OP_SYS, F3_PRIV, 1'b0, 5'd0, 3'b111, SYS_ECALL, 1'b0, 1'b1,
                            1'b1, 12'h000});
        send_beat(t_dec_in'{OP_SYS, F3_CSRRW, 1'b0, 5'd7, 3'b111, 2'd2, 1'b0, 1'b1,
                            1'b1, CSR_MTVEC});
        send_beat(t_dec_in'{OP_SYS, F3_CSRRSI, 1'b0, 5'd7, 3'b111, 2'd3, 1'b0, 1'b1,
                            1'b1, CSR_MEPC});
        send_beat(t_dec_in'{OP_SYS, F3_CSRRC, 1'b0, 5'd7, 3'b111, 2'd2, 1'b1, 1'b0,
                            1'b1, CSR_MCAUSE});
        send_beat(t_dec_in'{OP_SYS, F3_CSRRWI, 1'b0, 5'd7, 3'b111, 2'd3, 1'b1, 1'b1,
                            1'b0, CSR_MSTATUS});
        send_beat(t_dec_in'{OP_SYS, F3_CSRRS, 1'b0, 5'd7, 3'b111, 2'd2, 1'b0, 1'b1,
                            1'b1, 12'h301});
    endtask

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        src_idle_pct = 33;
        sink_idle_pct = 46;
        send_directed();
        run_phase(33, 46, RANDOM_BEATS / 3);
        run_phase(46, 33, RANDOM_BEATS / 3);
        run_phase(0, 0, RANDOM_BEATS - 2 * (RANDOM_BEATS / 3));
        in_valid <= 1'b0;
        while (board.due_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== sim.f =====
+incdir+hdl
hdl/rv32cd_pkg.sv
hdl/rv32cd_decode.sv
hdl/rv32_control_decoder_unit.sv
test/tb_rv32_control_decoder_unit.sv
